FILE: hdl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, constants and helpers for the packet traffic statistics block.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int TABLE_DEPTH  = 64;
    localparam int NUM_TABLES   = 6;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int FILL_W       = $clog2(TABLE_DEPTH + 1);
    localparam int TADDR_W      = $clog2(NUM_TABLES * TABLE_DEPTH);
    localparam int TBL_W        = 3;
    localparam int SCALAR_COUNT = 9;
    localparam int SC_W         = 4;
    localparam int STEP_W       = 3;

    // operation codes
    localparam logic OP_ACCOUNT = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DROP  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // read table select codes
    localparam logic [2:0] SEL_ETHERTYPE = 3'd0;
    localparam logic [2:0] SEL_BYTE_SUMS = 3'd1;
    localparam logic [2:0] SEL_PAIRS     = 3'd2;
    localparam logic [2:0] SEL_SCALARS   = 3'd7;

    // internal associative table numbers
    localparam logic [TBL_W-1:0] TBL_ETHERTYPE = 3'd0;
    localparam logic [TBL_W-1:0] TBL_PAIRS     = 3'd1;
    localparam logic [TBL_W-1:0] TBL_TCP_SRC   = 3'd2;
    localparam logic [TBL_W-1:0] TBL_TCP_DST   = 3'd3;
    localparam logic [TBL_W-1:0] TBL_UDP_SRC   = 3'd4;
    localparam logic [TBL_W-1:0] TBL_UDP_DST   = 3'd5;

    // scalar counter numbers
    localparam logic [SC_W-1:0] SC_PACKETS = 4'd0;
    localparam logic [SC_W-1:0] SC_BYTES   = 4'd1;
    localparam logic [SC_W-1:0] SC_ETH2    = 4'd2;
    localparam logic [SC_W-1:0] SC_8023    = 4'd3;
    localparam logic [SC_W-1:0] SC_IPV4    = 4'd4;
    localparam logic [SC_W-1:0] SC_TCP     = 4'd5;
    localparam logic [SC_W-1:0] SC_UDP     = 4'd6;
    localparam logic [SC_W-1:0] SC_ICMP    = 4'd7;
    localparam logic [SC_W-1:0] SC_PAIRS   = 4'd8;

    // protocol constants
    localparam logic [15:0] ETH2_MIN   = 16'h0600;
    localparam logic [7:0]  IPV4_PLAIN = 8'h45;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;

    typedef struct packed {
        logic        operation;
        logic [15:0] frame_length;
        logic [7:0]  type_high;
        logic [7:0]  type_low;
        logic [7:0]  first_payload_byte;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [2:0]  table_select;
        logic [7:0]  entry_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        entry_valid;
        logic [63:0] entry_key;
        logic [47:0] entry_value;
    } t_out_item;

    typedef struct packed {
        logic               rd_en;
        logic [TADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [TADDR_W-1:0] wr_addr;
        logic [63:0]        wr_key;
        logic [31:0]        wr_cnt;
    } t_tbl_port;

    typedef struct packed {
        logic        rd_en;
        logic [7:0]  rd_addr;
        logic        wr_en;
        logic [7:0]  wr_addr;
        logic [47:0] wr_data;
    } t_sum_port;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_PICK,
        S_SEARCH,
        S_FINISH,
        S_READ
    } t_state;

    function automatic logic [TADDR_W-1:0] tbl_addr(input logic [TBL_W-1:0] tbl,
                                                    input logic [IDX_W-1:0] idx);
        logic [TADDR_W+TBL_W-1:0] a;
        a = (TADDR_W+TBL_W)'(tbl) * (TADDR_W+TBL_W)'(TABLE_DEPTH)
            + (TADDR_W+TBL_W)'(idx);
        return a[TADDR_W-1:0];
    endfunction

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [15:0] b);
        logic [48:0] s;
        s = {1'b0, a} + 49'(b);
        return s[48] ? {48{1'b1}} : s[47:0];
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] a);
        return (a == {32{1'b1}}) ? a : a + 32'd1;
    endfunction

endpackage

FILE: hdl/pts_table_ram.sv
// ----------------------------------------------------------------------------
// pts_table_ram
// Key and count memories for all associative tables, one read and one write
// port each, registered read data.
// ----------------------------------------------------------------------------
module pts_table_ram (
    input  logic              i_clk,
    input  pts_pkg::t_tbl_port i_port,
    output logic [63:0]       o_key,
    output logic [31:0]       o_cnt
);
    import pts_pkg::*;

    logic [63:0] r_key_mem [NUM_TABLES*TABLE_DEPTH];
    logic [31:0] r_cnt_mem [NUM_TABLES*TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_port.wr_en) begin
            r_key_mem[i_port.wr_addr] <= i_port.wr_key;
            r_cnt_mem[i_port.wr_addr] <= i_port.wr_cnt;
        end
        if (i_port.rd_en) begin
            o_key <= r_key_mem[i_port.rd_addr];
            o_cnt <= r_cnt_mem[i_port.rd_addr];
        end
    end

endmodule

FILE: hdl/pts_sum_ram.sv
// ----------------------------------------------------------------------------
// pts_sum_ram
// Byte sum memory indexed by first payload byte; written flags make
// untouched entries read as zero after reset.
// ----------------------------------------------------------------------------
module pts_sum_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pts_pkg::t_sum_port i_port,
    output logic [47:0]       o_data
);
    import pts_pkg::*;

    logic [47:0] r_mem [256];
    logic [255:0] r_written;
    logic [47:0] r_rd_data;
    logic        r_rd_written;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_port.wr_en) begin
            r_written[i_port.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_port.wr_en) begin
            r_mem[i_port.wr_addr] <= i_port.wr_data;
        end
        if (i_port.rd_en) begin
            r_rd_data    <= r_mem[i_port.rd_addr];
            r_rd_written <= r_written[i_port.rd_addr];
        end
    end

    assign o_data = r_rd_written ? r_rd_data : 48'd0;

endmodule

FILE: hdl/packet_traffic_statistics_top.sv
// ----------------------------------------------------------------------------
// packet_traffic_statistics_top
// Per-packet traffic counters with associative tables held in memory.
// ----------------------------------------------------------------------------
// A read transaction fetches its entry at acceptance and registers the result in S_READ;
// an account transaction passes S_SUM, then S_PICK and S_SEARCH for its four table steps,
// then S_FINISH. A skipped table step only passes S_PICK; a searched table is scanned
// linearly, one memory read per cycle, up to its fill count or the first hit.
// One transaction at a time; the result strobe lasts one cycle, no receiver stall.
// Synchronous active-low reset empties every table and zeroes all counters.
// ----------------------------------------------------------------------------
module packet_traffic_statistics_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  pts_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_valid,
    output pts_pkg::t_out_item o_result
);
    import pts_pkg::*;

    t_state            r_state, n_state;
    t_in_item          r_item, n_item;
    logic [STEP_W-1:0] r_step, n_step;
    logic [FILL_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0]  r_idx_d, n_idx_d;
    logic              r_pend, n_pend;
    logic [FILL_W-1:0] r_fill [NUM_TABLES];
    logic [FILL_W-1:0] n_fill [NUM_TABLES];
    logic              r_drop, n_drop;
    logic              r_pair_new, n_pair_new;
    logic [47:0]       r_scalar [SCALAR_COUNT];
    logic [47:0]       n_scalar [SCALAR_COUNT];
    logic              r_valid, n_valid;
    t_out_item         r_result, n_result;

    t_tbl_port         tbl_port;
    t_sum_port         sum_port;
    logic [63:0]       tbl_key;
    logic [31:0]       tbl_cnt;
    logic [47:0]       sum_data;

    // decoded packet properties
    logic              accept;
    logic              is_eth2, is_ipv4, is_tcp, is_udp, is_icmp;
    logic [TBL_W-1:0]  cur_tbl;
    logic [63:0]       cur_key;
    logic              step_en;
    logic [FILL_W-1:0] fill_cur;
    logic              hit;
    logic              scan_done;
    logic [TBL_W-1:0]  rd_tbl;

    pts_table_ram u_table_ram (
        .i_clk  (i_clk),
        .i_port (tbl_port),
        .o_key  (tbl_key),
        .o_cnt  (tbl_cnt)
    );

    pts_sum_ram u_sum_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_port  (sum_port),
        .o_data  (sum_data)
    );

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    assign is_eth2 = {r_item.type_high, r_item.type_low} >= ETH2_MIN;
    assign is_ipv4 = r_item.first_payload_byte == IPV4_PLAIN;
    assign is_tcp  = r_item.ip_protocol == PROTO_TCP;
    assign is_udp  = r_item.ip_protocol == PROTO_UDP;
    assign is_icmp = r_item.ip_protocol == PROTO_ICMP;

    // map the search step to its table, key and enable
    always_comb begin
        cur_tbl = TBL_ETHERTYPE;
        cur_key = {48'd0, r_item.type_high, r_item.type_low};
        step_en = is_eth2;
        unique case (r_step)
            3'd1: begin
                cur_tbl = TBL_PAIRS;
                cur_key = {r_item.source_address, r_item.dest_address};
                step_en = is_ipv4;
            end
            3'd2: begin
                cur_tbl = is_tcp ? TBL_TCP_SRC : TBL_UDP_SRC;
                cur_key = {32'd0, r_item.source_address};
                step_en = is_ipv4 && (is_tcp || is_udp);
            end
            3'd3: begin
                cur_tbl = is_tcp ? TBL_TCP_DST : TBL_UDP_DST;
                cur_key = {32'd0, r_item.dest_address};
                step_en = is_ipv4 && (is_tcp || is_udp);
            end
            default: begin
            end
        endcase
    end

    assign fill_cur  = r_fill[cur_tbl];
    assign hit       = r_pend && (tbl_key == cur_key);
    assign scan_done = r_idx >= fill_cur;

    // table number for a read transaction
    always_comb begin
        priority if (r_item.table_select == SEL_ETHERTYPE) begin
            rd_tbl = TBL_ETHERTYPE;
        end else if (r_item.table_select == SEL_PAIRS) begin
            rd_tbl = TBL_PAIRS;
        end else begin
            rd_tbl = r_item.table_select - 3'd1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_item.operation == OP_READ) ? S_READ : S_SUM;
                end
            end
            S_SUM:    n_state = S_PICK;
            S_PICK: begin
                if (r_step == 3'd4) begin
                    n_state = S_FINISH;
                end else if (step_en) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (hit || scan_done) begin
                    n_state = S_PICK;
                end
            end
            S_FINISH: n_state = S_IDLE;
            S_READ:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_item     = r_item;
        n_step     = r_step;
        n_idx      = r_idx;
        n_idx_d    = r_idx_d;
        n_pend     = 1'b0;
        n_fill     = r_fill;
        n_drop     = r_drop;
        n_pair_new = r_pair_new;
        n_scalar   = r_scalar;
        n_valid    = 1'b0;
        n_result   = r_result;
        tbl_port   = '0;
        sum_port   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item     = i_item;
                    n_drop     = 1'b0;
                    n_pair_new = 1'b0;
                    // fetch the byte sum; also serves a byte-sum read
                    sum_port.rd_en   = 1'b1;
                    sum_port.rd_addr = (i_item.operation == OP_READ) ?
                                       i_item.entry_index : i_item.first_payload_byte;
                    tbl_port.rd_en   = 1'b1;
                    tbl_port.rd_addr = tbl_addr(
                        (i_item.table_select == SEL_ETHERTYPE) ? TBL_ETHERTYPE :
                        (i_item.table_select == SEL_PAIRS)     ? TBL_PAIRS :
                        TBL_W'(i_item.table_select - 3'd1),
                        i_item.entry_index[IDX_W-1:0]);
                end
            end
            S_SUM: begin
                // write back the byte sum for this first payload byte
                sum_port.wr_en   = 1'b1;
                sum_port.wr_addr = r_item.first_payload_byte;
                sum_port.wr_data = sat_add48(sum_data, r_item.frame_length);
                n_step           = '0;
            end
            S_PICK: begin
                if (r_step != 3'd4) begin
                    if (step_en) begin
                        n_idx = '0;
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end
            S_SEARCH: begin
                // issue the next slot read while comparing the previous one
                if (!scan_done) begin
                    tbl_port.rd_en   = 1'b1;
                    tbl_port.rd_addr = tbl_addr(cur_tbl, r_idx[IDX_W-1:0]);
                    n_pend           = 1'b1;
                    n_idx_d          = r_idx[IDX_W-1:0];
                    n_idx            = r_idx + FILL_W'(1);
                end
                if (hit) begin
                    tbl_port.wr_en   = 1'b1;
                    tbl_port.wr_addr = tbl_addr(cur_tbl, r_idx_d);
                    tbl_port.wr_key  = tbl_key;
                    tbl_port.wr_cnt  = sat_inc32(tbl_cnt);
                    n_step           = r_step + 3'd1;
                end else if (scan_done) begin
                    if (fill_cur < FILL_W'(TABLE_DEPTH)) begin
                        // insert into the first free slot
                        tbl_port.wr_en   = 1'b1;
                        tbl_port.wr_addr = tbl_addr(cur_tbl, fill_cur[IDX_W-1:0]);
                        tbl_port.wr_key  = cur_key;
                        tbl_port.wr_cnt  = 32'd1;
                        n_fill[cur_tbl]  = fill_cur + FILL_W'(1);
                        if (cur_tbl == TBL_PAIRS) begin
                            n_pair_new = 1'b1;
                        end
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_step = r_step + 3'd1;
                end
            end
            S_FINISH: begin
                n_scalar[SC_PACKETS] = sat_add48(r_scalar[SC_PACKETS], 16'd1);
                n_scalar[SC_BYTES]   = sat_add48(r_scalar[SC_BYTES], r_item.frame_length);
                if (is_eth2) begin
                    n_scalar[SC_ETH2] = sat_add48(r_scalar[SC_ETH2], 16'd1);
                end else begin
                    n_scalar[SC_8023] = sat_add48(r_scalar[SC_8023], 16'd1);
                end
                if (is_ipv4) begin
                    n_scalar[SC_IPV4] = sat_add48(r_scalar[SC_IPV4], 16'd1);
                    if (is_tcp) begin
                        n_scalar[SC_TCP] = sat_add48(r_scalar[SC_TCP], 16'd1);
                    end else if (is_udp) begin
                        n_scalar[SC_UDP] = sat_add48(r_scalar[SC_UDP], 16'd1);
                    end else if (is_icmp) begin
                        n_scalar[SC_ICMP] = sat_add48(r_scalar[SC_ICMP], 16'd1);
                    end
                end
                if (r_pair_new) begin
                    n_scalar[SC_PAIRS] = sat_add48(r_scalar[SC_PAIRS], 16'd1);
                end
                n_valid           = 1'b1;
                n_result          = '0;
                n_result.status   = r_drop ? ST_DROP : ST_OK;
            end
            S_READ: begin
                n_valid  = 1'b1;
                n_result = '0;
                if (r_item.table_select == SEL_BYTE_SUMS) begin
                    n_result.entry_valid = 1'b1;
                    n_result.entry_key   = {56'd0, r_item.entry_index};
                    n_result.entry_value = sum_data;
                end else if (r_item.table_select == SEL_SCALARS) begin
                    if (r_item.entry_index < 8'(SCALAR_COUNT)) begin
                        n_result.entry_valid = 1'b1;
                        n_result.entry_key   = {56'd0, r_item.entry_index};
                        n_result.entry_value = r_scalar[r_item.entry_index[SC_W-1:0]];
                    end else begin
                        n_result.status = ST_RANGE;
                    end
                end else if ({1'b0, r_item.entry_index} >= 9'(TABLE_DEPTH)) begin
                    n_result.status = ST_RANGE;
                end else if ({1'b0, r_item.entry_index} < 9'(r_fill[rd_tbl])) begin
                    n_result.entry_valid = 1'b1;
                    n_result.entry_key   = tbl_key;
                    n_result.entry_value = {16'd0, tbl_cnt};
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_idx      <= '0;
            r_pend     <= 1'b0;
            r_drop     <= 1'b0;
            r_pair_new <= 1'b0;
            r_valid    <= 1'b0;
            for (int t = 0; t < NUM_TABLES; t++) begin
                r_fill[t] <= '0;
            end
            for (int s = 0; s < SCALAR_COUNT; s++) begin
                r_scalar[s] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_idx      <= n_idx;
            r_pend     <= n_pend;
            r_drop     <= n_drop;
            r_pair_new <= n_pair_new;
            r_valid    <= n_valid;
            r_fill     <= n_fill;
            r_scalar   <= n_scalar;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_idx_d  <= n_idx_d;
        r_result <= n_result;
    end

endmodule
